// ===== rtl/console_line_editor_unit_assert.svh =====
// Assertion macros for the console line editor checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("console line editor check failed");

// Next-cycle implication, checked out of reset.
`define CLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("console line editor check failed");

`endif

// ===== rtl/cle_pkg.sv =====
// Shared types, codes and helper functions of the console line editor.
// No dependencies; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps

package cle_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int LIMIT_W = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL = 8'd0;
  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SP  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_LINE,
    ST_END
  } cle_state_e;

  typedef enum logic [1:0] {
    ECHO_CHAR,
    ECHO_CRLF,
    ECHO_ERASE
  } cle_echo_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } cle_mem_ctl_t;

  // Echo byte for a given step of an echo sequence
  function automatic logic [BYTE_W-1:0] echo_value(cle_echo_e mode, logic [1:0] step,
                                                   logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] v;
    case (mode)
      ECHO_CHAR:  v = rx;
      ECHO_CRLF:  v = (step == 2'd0) ? CH_CR : CH_LF;
      ECHO_ERASE: v = (step == 2'd1) ? CH_SP : CH_BS;
      default:    v = CH_NUL;
    endcase
    return v;
  endfunction

  // True on the final step of an echo sequence
  function automatic logic echo_done(cle_echo_e mode, logic [1:0] step);
    logic d;
    case (mode)
      ECHO_CHAR:  d = 1'b1;
      ECHO_CRLF:  d = (step == 2'd1);
      ECHO_ERASE: d = (step == 2'd2);
      default:    d = 1'b1;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/cle_line_mem.sv =====
// Line store: one write port, one read port, registered read data.
// Depends on cle_pkg for the byte width and the port control struct.
`timescale 1ns / 1ps

module cle_line_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                         clk_i,
  input  cle_pkg::cle_mem_ctl_t        ctl_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [cle_pkg::BYTE_W-1:0]   wdata_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [cle_pkg::BYTE_W-1:0]   rdata_o
);

  logic [cle_pkg::BYTE_W-1:0] mem_q [DEPTH];
  logic [cle_pkg::BYTE_W-1:0] rdata_q;

  // Write one byte
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one byte, hold the data between reads
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cle_seq.sv =====
// Editing sequencer: classifies each received byte, keeps the fill count,
// drives the line store and sequences echo, line and end words into an output register.
// Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_seq #(
  parameter int LINE_CAP = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [cle_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic [cle_pkg::LIMIT_W-1:0]   line_limit_i,
  output cle_pkg::cle_mem_ctl_t         mem_ctl_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [cle_pkg::BYTE_W-1:0]    mem_wdata_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [cle_pkg::BYTE_W-1:0]    mem_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cle_pkg::KIND_W-1:0]    out_kind_o,
  output logic [cle_pkg::BYTE_W-1:0]    out_value_o,
  output logic                          out_last_o
);

  localparam int CMPW = ((CW > cle_pkg::LIMIT_W) ? CW : cle_pkg::LIMIT_W) + 1;

  cle_pkg::cle_state_e state_q, state_d;
  cle_pkg::cle_echo_e  mode_q, mode_d;
  logic [1:0]                 step_q, step_d;
  logic [cle_pkg::BYTE_W-1:0] byte_q, byte_d;
  logic                       deliver_q, deliver_d;
  logic [CW-1:0]              fill_q, fill_d;
  logic [CW-1:0]              len_q, len_d;
  logic [CW-1:0]              rd_idx_q, rd_idx_d;
  logic                       rd_vld_q, rd_vld_d;
  logic                       out_valid_q, out_valid_d;
  logic [cle_pkg::KIND_W-1:0] out_kind_q, out_kind_d;
  logic [cle_pkg::BYTE_W-1:0] out_value_q, out_value_d;
  logic                       out_last_q, out_last_d;

  logic            slot_free, accept, is_eol, is_bs, store_ok, hit;
  logic            echo_emit, echo_end, line_emit, line_issue, line_done, end_emit;
  logic [CMPW-1:0] lim_ext, lim_eff, fill_new;

  // Classify the incoming byte
  assign accept = rx_valid_i && (state_q == cle_pkg::ST_IDLE);
  assign is_eol = (rx_byte_i == cle_pkg::CH_CR) || (rx_byte_i == cle_pkg::CH_LF);
  assign is_bs  = (rx_byte_i == cle_pkg::CH_BS) || (rx_byte_i == cle_pkg::CH_DEL);

  // Clamp the limit and test for a full line
  assign lim_ext = CMPW'(line_limit_i);
  always_comb begin
    if (lim_ext < CMPW'(2)) begin
      lim_eff = CMPW'(2);
    end else if (lim_ext > CMPW'(LINE_CAP)) begin
      lim_eff = CMPW'(LINE_CAP);
    end else begin
      lim_eff = lim_ext;
    end
  end
  assign store_ok = CMPW'(fill_q) < CMPW'(LINE_CAP);
  assign fill_new = store_ok ? (CMPW'(fill_q) + CMPW'(1)) : CMPW'(fill_q);
  assign hit      = (fill_new + CMPW'(1)) >= lim_eff;

  // Emission conditions
  assign slot_free  = !out_valid_q || out_ready_i;
  assign echo_emit  = (state_q == cle_pkg::ST_ECHO) && slot_free;
  assign echo_end   = cle_pkg::echo_done(mode_q, step_q);
  assign line_emit  = (state_q == cle_pkg::ST_LINE) && rd_vld_q && slot_free;
  assign line_issue = (state_q == cle_pkg::ST_LINE) && (rd_idx_q < len_q)
                      && (!rd_vld_q || line_emit);
  assign line_done  = (state_q == cle_pkg::ST_LINE) && (rd_idx_q == len_q) && !rd_vld_q;
  assign end_emit   = (state_q == cle_pkg::ST_END) && slot_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cle_pkg::ST_IDLE: begin
        if (accept) begin
          if (is_bs && (fill_q == '0)) begin
            state_d = cle_pkg::ST_IDLE;
          end else begin
            state_d = cle_pkg::ST_ECHO;
          end
        end
      end
      cle_pkg::ST_ECHO: begin
        if (echo_emit && echo_end) begin
          state_d = deliver_q ? cle_pkg::ST_LINE : cle_pkg::ST_IDLE;
        end
      end
      cle_pkg::ST_LINE: begin
        if (line_done) begin
          state_d = cle_pkg::ST_END;
        end
      end
      cle_pkg::ST_END: begin
        if (end_emit) begin
          state_d = cle_pkg::ST_IDLE;
        end
      end
      default: state_d = cle_pkg::ST_IDLE;
    endcase
  end

  // Datapath, store access and output word
  always_comb begin
    mode_d      = mode_q;
    step_d      = step_q;
    byte_d      = byte_q;
    deliver_d   = deliver_q;
    fill_d      = fill_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = rd_vld_q;
    out_kind_d  = out_kind_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_ctl_o   = '0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = rx_byte_i;
    mem_raddr_o = rd_idx_q[AW-1:0];

    // Take a byte and update the line
    if (accept) begin
      byte_d   = rx_byte_i;
      step_d   = 2'd0;
      rd_idx_d = '0;
      rd_vld_d = 1'b0;
      if (is_eol) begin
        mode_d    = cle_pkg::ECHO_CRLF;
        deliver_d = 1'b1;
        len_d     = fill_q;
        fill_d    = '0;
      end else if (is_bs) begin
        mode_d    = cle_pkg::ECHO_ERASE;
        deliver_d = 1'b0;
        if (fill_q != '0) begin
          fill_d = fill_q - CW'(1);
        end
      end else begin
        mode_d          = cle_pkg::ECHO_CHAR;
        mem_ctl_o.wr_en = store_ok;
        if (hit) begin
          deliver_d = 1'b1;
          len_d     = CW'(fill_new);
          fill_d    = '0;
        end else begin
          deliver_d = 1'b0;
          fill_d    = CW'(fill_new);
        end
      end
    end

    // Echo one byte
    if (echo_emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = cle_pkg::KIND_ECHO;
      out_value_d = cle_pkg::echo_value(mode_q, step_q, byte_q);
      out_last_d  = echo_end && !deliver_q;
      step_d      = step_q + 2'd1;
    end

    // Walk the line store, one read ahead of the output
    if (line_issue) begin
      mem_ctl_o.rd_en = 1'b1;
      rd_idx_d        = rd_idx_q + CW'(1);
    end
    if (line_issue) begin
      rd_vld_d = 1'b1;
    end else if (line_emit) begin
      rd_vld_d = 1'b0;
    end
    if (line_emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = cle_pkg::KIND_LINE;
      out_value_d = mem_rdata_i;
      out_last_d  = 1'b0;
    end

    // Close the line
    if (end_emit) begin
      out_valid_d = 1'b1;
      out_kind_d  = cle_pkg::KIND_END;
      out_value_d = cle_pkg::CH_NUL;
      out_last_d  = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cle_pkg::ST_IDLE;
      fill_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    step_q      <= step_d;
    byte_q      <= byte_d;
    deliver_q   <= deliver_d;
    len_q       <= len_d;
    rd_idx_q    <= rd_idx_d;
    out_kind_q  <= out_kind_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign rx_ready_o  = (state_q == cle_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/console_line_editor_unit.sv =====
// Console line editor top level: limit register, sequencer and line store.
// Depends on cle_pkg, cle_seq and cle_line_mem.
//
//   channel | direction | handshake            | payload
//   rx      | in        | rx_valid_i/ready_o   | rx_byte_i
//   out     | out       | out_valid_o/ready_i  | out_kind_o, out_value_o, out_last_o
//   cfg     | in        | cfg_we_i (no wait)   | cfg_wdata_i (line limit)
//
// A byte is taken only in the idle state; its words leave one per cycle when out_ready_i
// is high. An echo-only byte gives one to three echo words; a line of n bytes adds
// a start of the read of the line store one byte ahead, n line words, a step to close
// the walk and the end word (an empty line has only the closing step and the end word).
// A backspace on an empty line gives no word.
// Reset clears the fill count and sets the limit to 32; the store needs no clearing.
// A stalled output holds its word; the next byte may be taken while the last word waits.
`timescale 1ns / 1ps

module console_line_editor_unit #(
  parameter int LINE_CAP = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [cle_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [cle_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cle_pkg::KIND_W-1:0]    out_kind_o,
  output logic [cle_pkg::BYTE_W-1:0]    out_value_o,
  output logic                          out_last_o
);

  localparam int AW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int CW = $clog2(LINE_CAP + 1);

  logic [cle_pkg::LIMIT_W-1:0] line_limit_q;
  cle_pkg::cle_mem_ctl_t       mem_ctl;
  logic [AW-1:0]               mem_waddr, mem_raddr;
  logic [cle_pkg::BYTE_W-1:0]  mem_wdata, mem_rdata;

  // Hold the line limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_limit_q <= cle_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      line_limit_q <= cfg_wdata_i;
    end
  end

  cle_seq #(
    .LINE_CAP (LINE_CAP),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .line_limit_i (line_limit_q),
    .mem_ctl_o    (mem_ctl),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .out_value_o  (out_value_o),
    .out_last_o   (out_last_o)
  );

  cle_line_mem #(
    .DEPTH (LINE_CAP),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checks of the console line editor, bound to the top level.
// Depends on cle_pkg and console_line_editor_unit_assert.svh.
`timescale 1ns / 1ps
`include "console_line_editor_unit_assert.svh"

module cle_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rx_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [cle_pkg::KIND_W-1:0]    out_kind_o,
  input logic [cle_pkg::BYTE_W-1:0]    out_value_o,
  input logic                          out_last_o
);

  logic                                     out_stall;
  logic [cle_pkg::KIND_W+cle_pkg::BYTE_W:0] out_word;
  logic                                     end_word, end_ok;

  // Gather the output word and its conditions
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_word  = {out_kind_o, out_value_o, out_last_o};
  assign end_word  = out_valid_o && (out_kind_o == cle_pkg::KIND_END);
  assign end_ok    = (out_value_o == cle_pkg::CH_NUL) && out_last_o;

  // A stalled word holds
  `CLE_ASSERT_NXT(a_out_hold, out_stall, out_valid_o && $stable(out_word))

  // The end marker carries zero and closes the byte's words
  `CLE_ASSERT_IMP(a_end_word, end_word, end_ok)

  // A line byte is always followed by more words
  `CLE_ASSERT_IMP(a_line_not_last, out_valid_o && (out_kind_o == cle_pkg::KIND_LINE), !out_last_o)

  // A word still waiting when a new byte may enter is the final one
  `CLE_ASSERT_IMP(a_idle_last, rx_ready_o && out_valid_o, out_last_o)

endmodule

bind console_line_editor_unit cle_checker u_cle_checker (.*);

// ===== test/console_line_editor_unit_tb.sv =====
// Testbench for console_line_editor_unit: drives received bytes and limit writes,
// predicts the echo and line words, and checks every output word in order.
// Depends on cle_pkg and the console_line_editor_unit RTL.
`timescale 1ns / 1ps

module console_line_editor_unit_tb;
  import cle_pkg::*;

  localparam int LINE_CAP   = 32;
  localparam int PHASE_LEN  = 48;
  localparam int STALL_STOP = 5000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] value;
    logic              last;
  } editor_word_t;

  // Line editor predictor and the words it still expects
  class line_echo_predictor;
    logic [BYTE_W-1:0]  line_bytes[LINE_CAP];
    int unsigned        fill;
    logic [LIMIT_W-1:0] limit;
    editor_word_t       pending_words[$];
    int unsigned        errors;

    function new();
      fill = 0;
      limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int unsigned eff_limit();
      int unsigned lim;
      lim = limit;
      if (lim < 2) lim = 2;
      if (lim > LINE_CAP) lim = LINE_CAP;
      return lim;
    endfunction

    function void push_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value);
      editor_word_t w;
      w.kind = kind;
      w.value = value;
      w.last = 1'b0;
      pending_words.push_back(w);
    endfunction

    // Hand out the stored line and the end marker, then clear the fill
    function void hand_out_line();
      for (int i = 0; i < fill && i < LINE_CAP; i++) push_word(KIND_LINE, line_bytes[i]);
      push_word(KIND_END, CH_NUL);
      fill = 0;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      int n0;
      n0 = pending_words.size();
      if (b == CH_CR || b == CH_LF) begin
        push_word(KIND_ECHO, CH_CR);
        push_word(KIND_ECHO, CH_LF);
        hand_out_line();
      end else if (b == CH_BS || b == CH_DEL) begin
        // erase only when something is stored
        if (fill > 0) begin
          fill--;
          push_word(KIND_ECHO, CH_BS);
          push_word(KIND_ECHO, CH_SP);
          push_word(KIND_ECHO, CH_BS);
        end
      end else begin
        if (fill < LINE_CAP) begin
          line_bytes[fill] = b;
          fill++;
        end
        push_word(KIND_ECHO, b);
        if (fill >= eff_limit() - 1) hand_out_line();
      end
      // mark the final word caused by this byte
      if (pending_words.size() > n0) pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    function void match_word(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] value, logic last);
      editor_word_t w;
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d value 0x%02h last %0b", kind, value, last);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      if (w.kind !== kind) begin
        $error("out_kind: expected %0d, actual %0d", w.kind, kind);
        errors++;
      end
      if (w.value !== value) begin
        $error("out_value: expected 0x%02h, actual 0x%02h", w.value, value);
        errors++;
      end
      if (w.last !== last) begin
        $error("out_last: expected %0b, actual %0b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                rx_valid_i  = 1'b0;
  logic                rx_ready_o;
  logic [BYTE_W-1:0]   rx_byte_i   = '0;
  logic                cfg_we_i    = 1'b0;
  logic [LIMIT_W-1:0]  cfg_wdata_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [KIND_W-1:0]   out_kind_o;
  logic [BYTE_W-1:0]   out_value_o;
  logic                out_last_o;

  line_echo_predictor predictor;
  int unsigned        idle_pct = 25;
  int unsigned        stall_cycles = 0;

  console_line_editor_unit #(
    .LINE_CAP(LINE_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_kind_o (out_kind_o),
    .out_value_o(out_value_o),
    .out_last_o (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // Stall the output at random and check every accepted word
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      predictor.match_word(out_kind_o, out_value_o, out_last_o);
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((rx_valid_i && rx_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_STOP) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one byte, with a random gap first, and hold it until taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < idle_pct) begin
      rx_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    predictor.take_byte(b);
  endtask

  // Drain all expected words, let the block settle, then write the limit
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    rx_valid_i <= 1'b0;
    while (predictor.pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    predictor.set_limit(v);
  endtask

  // Mostly typed text with edits and line ends, plus arbitrary bytes
  function automatic logic [BYTE_W-1:0] random_byte(int unsigned term_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < term_pct) return ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF;
    if (r < term_pct + 8) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
    if (r < term_pct + 20) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(32, 126));
  endfunction

  initial begin
    logic [BYTE_W-1:0]  opening[12];
    logic [LIMIT_W-1:0] phase_limits[9];
    int unsigned        term_pct;

    opening = '{8'h00, 8'hFF, 8'h41, CH_BS, CH_DEL, CH_CR,
                CH_BS, CH_DEL, CH_LF, 8'h80, 8'h7E, CH_CR};
    phase_limits = '{6'd63, 6'd2, 6'd32, 6'd5, 6'd33, 6'd17, 6'd31, 6'd4, 6'd0};
    phase_limits[8] = LIMIT_W'($urandom_range(0, 63));
    predictor = new();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, erase on non-empty and empty lines, both line ends
    foreach (opening[i]) send_byte(opening[i]);

    // Lower the limit below the current fill; next byte completes the line
    for (int i = 0; i < 6; i++) send_byte(8'h61 + BYTE_W'(i));
    write_limit(6'd3);
    send_byte(8'h67);

    // Limits under the floor clamp to two: each byte is a whole line
    write_limit(6'd0);
    send_byte(8'h78);
    write_limit(6'd1);
    send_byte(8'h79);

    // Random phases over a spread of limits, one of them without idling
    for (int p = 0; p < 9; p++) begin
      write_limit(phase_limits[p]);
      idle_pct = (p == 2) ? 0 : 25;
      term_pct = (predictor.eff_limit() > 16) ? 3 : 8;
      for (int i = 0; i < PHASE_LEN; i++) send_byte(random_byte(term_pct));
    end

    // Wait out the remaining words and any trailing work
    rx_valid_i <= 1'b0;
    idle_pct = 25;
    while (predictor.pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (predictor.errors == 0 && predictor.pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_line_mem.sv
rtl/cle_seq.sv
rtl/console_line_editor_unit.sv
rtl/cle_checker.sv
test/console_line_editor_unit_tb.sv
